@@ sv/rmc_pkg.sv @@
package rmc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TEXT_W    = 56;
  localparam int unsigned INDEX_W   = 6;

  // Capture window geometry, counted from the byte after the 'R'.
  localparam int unsigned CAPTURE_LENGTH = 40;
  localparam int unsigned FIELD_CHARS    = 7;
  localparam int unsigned STATUS_OFFSET  = 14;
  localparam int unsigned LAT_OFFSET     = 16;
  localparam int unsigned LON_OFFSET     = 29;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;

  // Position shown until the first valid fix: "1748335" and "7838706".
  localparam logic [TEXT_W-1:0] LAT_RESET = 56'h31373438333335;
  localparam logic [TEXT_W-1:0] LON_RESET = 56'h37383338373036;

  typedef struct packed {
    logic              fix_valid;
    logic [TEXT_W-1:0] latitude_text;
    logic [TEXT_W-1:0] longitude_text;
  } rmc_result_t;

endpackage

@@ sv/rmc_parser.sv @@
module rmc_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [rmc_pkg::BYTE_W-1:0] byte_i,
  output logic                      done_o,
  output rmc_pkg::rmc_result_t      result_o
);
  import rmc_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_G       = 3'd1,
    PH_P       = 3'd2,
    PH_R       = 3'd3,
    PH_CAPTURE = 3'd4
  } phase_e;

  localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(CAPTURE_LENGTH - 1);
  localparam logic [INDEX_W-1:0] STAT_IDX = INDEX_W'(STATUS_OFFSET);
  localparam logic [INDEX_W-1:0] LAT_LO   = INDEX_W'(LAT_OFFSET);
  localparam logic [INDEX_W-1:0] LAT_HI   = INDEX_W'(LAT_OFFSET + FIELD_CHARS);
  localparam logic [INDEX_W-1:0] LON_LO   = INDEX_W'(LON_OFFSET);
  localparam logic [INDEX_W-1:0] LON_HI   = INDEX_W'(LON_OFFSET + FIELD_CHARS);

  phase_e              phase_q, phase_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  logic [BYTE_W-1:0]   status_q, status_d;
  logic [TEXT_W-1:0]   lat_cap_q, lat_cap_d;
  logic [TEXT_W-1:0]   lon_cap_q, lon_cap_d;
  logic [TEXT_W-1:0]   lat_held_q, lat_held_d;
  logic [TEXT_W-1:0]   lon_held_q, lon_held_d;
  logic                last;
  logic                fix;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    status_d   = status_q;
    lat_cap_d  = lat_cap_q;
    lon_cap_d  = lon_cap_q;
    lat_held_d = lat_held_q;
    lon_held_d = lon_held_q;
    last       = 1'b0;
    fix        = 1'b0;
    case (phase_q)
      PH_G: phase_d = (byte_i == CHAR_G) ? PH_P : PH_HUNT;
      PH_P: phase_d = (byte_i == CHAR_P) ? PH_R : PH_HUNT;
      PH_R: begin
        if (byte_i == CHAR_R) begin
          phase_d   = PH_CAPTURE;
          idx_d     = '0;
          status_d  = '0;
          lat_cap_d = '0;
          lon_cap_d = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CAPTURE: begin
        if (idx_q == STAT_IDX) status_d = byte_i;
        if (idx_q >= LAT_LO && idx_q < LAT_HI) lat_cap_d = {lat_cap_q[TEXT_W-BYTE_W-1:0], byte_i};
        if (idx_q >= LON_LO && idx_q < LON_HI) lon_cap_d = {lon_cap_q[TEXT_W-BYTE_W-1:0], byte_i};
        if (idx_q >= LAST_IDX) begin
          last    = 1'b1;
          idx_d   = '0;
          phase_d = PH_HUNT;
          // Status byte sits well before the end, so the stored copy is final.
          fix     = (status_q == CHAR_A);
          if (fix) begin
            lat_held_d = lat_cap_d;
            lon_held_d = lon_cap_d;
          end
        end else begin
          idx_d = idx_q + INDEX_W'(1);
        end
      end
      default: phase_d = (byte_i == CHAR_DOLLAR) ? PH_G : PH_HUNT;
    endcase
  end

  assign done_o                  = step_i & last;
  assign result_o.fix_valid      = fix;
  assign result_o.latitude_text  = lat_held_d;
  assign result_o.longitude_text = lon_held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      idx_q      <= '0;
      status_q   <= '0;
      lat_cap_q  <= '0;
      lon_cap_q  <= '0;
      lat_held_q <= LAT_RESET;
      lon_held_q <= LON_RESET;
    end else if (step_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      status_q   <= status_d;
      lat_cap_q  <= lat_cap_d;
      lon_cap_q  <= lon_cap_d;
      lat_held_q <= lat_held_d;
      lon_held_q <= lon_held_d;
    end
  end

endmodule

@@ sv/rmc_out_reg.sv @@
module rmc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  rmc_pkg::rmc_result_t result_i,
  input  logic                 stall_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output rmc_pkg::rmc_result_t result_o
);
  import rmc_pkg::*;

  logic        valid_q, valid_d;
  rmc_result_t data_q;

  // Free when empty or when the held beat leaves this cycle.
  assign ready_o = ~valid_q | ~stall_i;

  always_comb begin
    valid_d = valid_q & stall_i;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

@@ sv/nmea_rmc_position_extractor.sv @@
// Channel   Direction  Handshake                 Payload
// rx        in         rx_valid_i / rx_stall_o   rx_byte_i
// res       out        res_valid_o / res_stall_i fix_valid_o, latitude_text_o,
//                                                longitude_text_o
//
// One byte a cycle sustained while res is not stalled; the closing byte passes the
// input register, then the result register, before its result is valid.
// The parser step (compare, shift-in, index increment) sets the cycle.
// Reset clears the hunt state and loads the default held position.
// Stall on res holds the result register; rx stalls only when the input
// register is full and the result register cannot take a new beat.
module nmea_rmc_position_extractor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rx_valid_i,
  output logic                       rx_stall_o,
  input  logic [rmc_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output logic                       fix_valid_o,
  output logic [rmc_pkg::TEXT_W-1:0] latitude_text_o,
  output logic [rmc_pkg::TEXT_W-1:0] longitude_text_o
);
  import rmc_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              step;
  logic              done;
  logic              out_ready;
  rmc_result_t       parse_res;
  rmc_result_t       out_res;

  // Advance the held byte only when the result register has room, so a
  // closing byte never has to wait once it is in the parser.
  assign step       = in_valid_q & out_ready;
  assign rx_stall_o = in_valid_q & ~out_ready;

  always_comb begin
    in_valid_d = in_valid_q & ~step;
    if (rx_valid_i && !rx_stall_o) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && !rx_stall_o) in_byte_q <= rx_byte_i;
  end

  rmc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .done_o   (done),
    .result_o (parse_res)
  );

  rmc_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (done),
    .result_i (parse_res),
    .stall_i  (res_stall_i),
    .ready_o  (out_ready),
    .valid_o  (res_valid_o),
    .result_o (out_res)
  );

  assign fix_valid_o      = out_res.fix_valid;
  assign latitude_text_o  = out_res.latitude_text;
  assign longitude_text_o = out_res.longitude_text;

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmc_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  // A correct run never goes near this: the longest quiet stretch is a sender gap
  // or receiver stall streak plus the trip through the input and result registers.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned REPORT_LIMIT = 10;
  // Each random phase stops once it has sent this many bytes and seen this many fixes.
  localparam int unsigned PHASE_BYTES  = 290;
  localparam int unsigned PHASE_FIXES  = 6;

  localparam logic [31:0]       RMC_PREFIX = {CHAR_DOLLAR, CHAR_G, CHAR_P, CHAR_R};
  localparam logic [BYTE_W-1:0] CHAR_V     = "V";
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = "0";
  localparam logic [BYTE_W-1:0] CHAR_NINE  = "9";
  localparam logic [BYTE_W-1:0] PRINT_LO   = " ";
  localparam logic [BYTE_W-1:0] PRINT_HI   = "~";

  typedef enum logic [2:0] {
    HUNT_DOLLAR,
    HUNT_G,
    HUNT_P,
    HUNT_R,
    CAPTURING
  } parse_phase_e;

  // One row of the directed table: a lead-in (right aligned, lead_len bytes),
  // then a 40-byte capture body built from status, latitude, longitude and filler.
  // Rows with typed set carry the fix that the body must close with.
  typedef struct packed {
    logic [63:0]       lead;
    logic [3:0]        lead_len;
    logic [BYTE_W-1:0] status;
    logic [TEXT_W-1:0] lat;
    logic [TEXT_W-1:0] lon;
    logic [BYTE_W-1:0] fill;
    logic              typed;
    rmc_result_t       want;
  } sentence_row_t;

  localparam sentence_row_t DIRECTED_ROWS [12] = '{
    // Void status right after reset: the default position comes back.
    '{64'(RMC_PREFIX), 4'd4, CHAR_V, "0000000", "0000000", ",", 1'b1,
      '{1'b0, LAT_RESET, LON_RESET}},
    // Active fix replaces the held position.
    '{64'(RMC_PREFIX), 4'd4, CHAR_A, "1234567", "7654321", ",", 1'b1,
      '{1'b1, "1234567", "7654321"}},
    // All-zero body: status is not 'A', previous position stays.
    '{64'(RMC_PREFIX), 4'd4, 8'h00, 56'h0, 56'h0, 8'h00, 1'b1,
      '{1'b0, "1234567", "7654321"}},
    // All-ones latitude, zero longitude, all-ones filler.
    '{64'(RMC_PREFIX), 4'd4, CHAR_A, {7{8'hFF}}, 56'h0, 8'hFF, 1'b1,
      '{1'b1, {7{8'hFF}}, 56'h0}},
    // Status 0xFF: no update.
    '{64'(RMC_PREFIX), 4'd4, 8'hFF, "9999999", "9999999", 8'hFF, 1'b1,
      '{1'b0, {7{8'hFF}}, 56'h0}},
    // Doubled dollar: the second one is the mismatch and is not retried as a start.
    '{64'("$$GPR"), 4'd5, CHAR_A, "5555555", "5555555", ",", 1'b0, '0},
    // Dollar where 'R' belongs: same rule one step later.
    '{64'("$GP$GPR"), 4'd7, CHAR_A, "4444444", "4444444", ",", 1'b0, '0},
    // Plain mismatch in the middle, then a clean prefix.
    '{64'("$GX$GPR"), 4'd7, CHAR_A, "3141592", "2718281", ",", 1'b0, '0},
    // No dollar at all.
    '{64'("GPR"), 4'd3, CHAR_A, "6666666", "6666666", ",", 1'b0, '0},
    // Lower-case status does not count as active.
    '{64'(RMC_PREFIX), 4'd4, "a", "8888888", "8888888", ",", 1'b0, '0},
    // Dollar signs inside the body are captured, not hunted.
    '{64'(RMC_PREFIX), 4'd4, CHAR_A, "0001234", "0005678", "$", 1'b0, '0},
    // A second prefix inside the capture window shifts the fields.
    '{64'("$GPR$GPR"), 4'd8, CHAR_A, "2222222", "3333333", ",", 1'b0, '0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                rx_valid_i  = 1'b0;
  logic                rx_stall_o;
  logic [BYTE_W-1:0]   rx_byte_i   = '0;
  logic                res_valid_o;
  logic                res_stall_i = 1'b0;
  logic                fix_valid_o;
  logic [TEXT_W-1:0]   latitude_text_o;
  logic [TEXT_W-1:0]   longitude_text_o;

  // Predictor state: the parser as the block should hold it.
  parse_phase_e        phase_model;
  logic [INDEX_W-1:0]  offset_model;
  logic [BYTE_W-1:0]   status_model;
  logic [TEXT_W-1:0]   lat_capture;
  logic [TEXT_W-1:0]   lon_capture;
  logic [TEXT_W-1:0]   lat_shown;
  logic [TEXT_W-1:0]   lon_shown;

  rmc_result_t         pending_fixes [$];
  rmc_result_t         oldest_fix;
  int unsigned         bytes_sent      = 0;
  int unsigned         fixes_predicted = 0;
  int unsigned         failures        = 0;
  int unsigned         send_idle_pct   = 23;
  int unsigned         recv_stall_pct  = 48;
  int unsigned         quiet_cycles;

  nmea_rmc_position_extractor uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_stall_o       (rx_stall_o),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .fix_valid_o      (fix_valid_o),
    .latitude_text_o  (latitude_text_o),
    .longitude_text_o (longitude_text_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the parser by one accepted byte; return 1 when the byte closes a
  // capture, with the fix that must leave the block.
  function automatic logic parse_byte(input logic [BYTE_W-1:0] data,
                                      output rmc_result_t fix);
    parse_byte = 1'b0;
    fix        = '0;
    case (phase_model)
      HUNT_G: phase_model = (data == CHAR_G) ? HUNT_P : HUNT_DOLLAR;
      HUNT_P: phase_model = (data == CHAR_P) ? HUNT_R : HUNT_DOLLAR;
      HUNT_R: begin
        // 'R' opens a capture: clear everything collected so far.
        if (data == CHAR_R) begin
          phase_model  = CAPTURING;
          offset_model = '0;
          status_model = '0;
          lat_capture  = '0;
          lon_capture  = '0;
        end else begin
          phase_model = HUNT_DOLLAR;
        end
      end
      CAPTURING: begin
        if (offset_model == STATUS_OFFSET)
          status_model = data;
        if (offset_model >= LAT_OFFSET && offset_model < LAT_OFFSET + FIELD_CHARS)
          lat_capture = {lat_capture[TEXT_W-BYTE_W-1:0], data};
        if (offset_model >= LON_OFFSET && offset_model < LON_OFFSET + FIELD_CHARS)
          lon_capture = {lon_capture[TEXT_W-BYTE_W-1:0], data};
        if (offset_model + 1 < CAPTURE_LENGTH) begin
          offset_model = offset_model + 1'b1;
        end else begin
          offset_model  = '0;
          phase_model   = HUNT_DOLLAR;
          fix.fix_valid = (status_model == CHAR_A);
          if (fix.fix_valid) begin
            lat_shown = lat_capture;
            lon_shown = lon_capture;
          end
          fix.latitude_text  = lat_shown;
          fix.longitude_text = lon_shown;
          parse_byte         = 1'b1;
        end
      end
      // Hunting, and any phase code that should never occur.
      default: phase_model = (data == CHAR_DOLLAR) ? HUNT_G : HUNT_DOLLAR;
    endcase
  endfunction

  // Seven digits most of the time, otherwise arbitrary bytes.
  function automatic logic [TEXT_W-1:0] random_field();
    logic [TEXT_W-1:0] text;
    text = {$urandom, 24'($urandom)};
    if ($urandom_range(0, 9) < 7)
      for (int k = 0; k < FIELD_CHARS; k++)
        text[8*k +: 8] = 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
    return text;
  endfunction

  // Drive one beat on rx after a random gap, hold it until accepted, then
  // queue whatever fix it closes (the typed one where the row gives it).
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic use_typed,
                           input rmc_result_t typed_fix);
    rmc_result_t fix;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= data;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (parse_byte(data, fix)) begin
      fixes_predicted++;
      pending_fixes.push_back(use_typed ? typed_fix : fix);
    end
  endtask

  // Send the lead-in, then a full capture body. Scrambled filler mixes
  // printable text with the odd arbitrary byte.
  task automatic send_sentence(input sentence_row_t row, input logic scramble);
    logic [BYTE_W-1:0] data;
    for (int j = 0; j < row.lead_len; j++)
      send_byte(row.lead[8*(row.lead_len-1-j) +: 8], 1'b0, '0);
    for (int i = 0; i < CAPTURE_LENGTH; i++) begin
      if (i == STATUS_OFFSET)
        data = row.status;
      else if (i >= LAT_OFFSET && i < LAT_OFFSET + FIELD_CHARS)
        data = row.lat[8*(LAT_OFFSET + FIELD_CHARS - 1 - i) +: 8];
      else if (i >= LON_OFFSET && i < LON_OFFSET + FIELD_CHARS)
        data = row.lon[8*(LON_OFFSET + FIELD_CHARS - 1 - i) +: 8];
      else if (scramble)
        data = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(PRINT_LO, PRINT_HI));
      else
        data = row.fill;
      send_byte(data, row.typed, row.want);
    end
  endtask

  // Mostly clean sentences with random content; the rest is broken prefixes
  // and bare noise, so the hunt logic sees every way out of each phase.
  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    sentence_row_t     row;
    logic [BYTE_W-1:0] wanted;
    logic [BYTE_W-1:0] bad;
    int unsigned       pick;
    int unsigned       cut;
    int unsigned       byte_goal;
    int unsigned       fix_goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    byte_goal      = bytes_sent + PHASE_BYTES;
    fix_goal       = fixes_predicted + PHASE_FIXES;
    while (bytes_sent < byte_goal || fixes_predicted < fix_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        row          = '0;
        row.lead     = 64'(RMC_PREFIX);
        row.lead_len = 4'd4;
        case ($urandom_range(0, 4))
          0, 1, 2: row.status = CHAR_A;
          3:       row.status = CHAR_V;
          default: row.status = 8'($urandom_range(0, 255));
        endcase
        row.lat = random_field();
        row.lon = random_field();
        send_sentence(row, 1'b1);
      end else if (pick < 85) begin
        // Break the prefix after one to three good characters.
        cut = $urandom_range(1, 3);
        for (int j = 0; j < cut; j++)
          send_byte(RMC_PREFIX[8*(3-j) +: 8], 1'b0, '0);
        wanted = RMC_PREFIX[8*(3-cut) +: 8];
        if ($urandom_range(0, 2) == 0) begin
          bad = CHAR_DOLLAR;
        end else begin
          do bad = 8'($urandom_range(0, 255)); while (bad == wanted);
        end
        send_byte(bad, 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  // Drop valid and hold the sender until every queued fix has come out.
  task automatic hold_until_drained();
    rx_valid_i <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
  endtask

  function automatic void flag_mismatch(input string what, input logic [TEXT_W-1:0] want,
                                        input logic [TEXT_W-1:0] got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Receiver: stall at random, and check every result beat against the
  // oldest pending fix. Values read here are the ones the edge samples.
  always @(posedge clk_i) begin
    res_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_fixes.size() == 0) begin
        flag_mismatch("result with no fix pending, latitude", '0, latitude_text_o);
      end else begin
        oldest_fix = pending_fixes.pop_front();
        if (fix_valid_o !== oldest_fix.fix_valid)
          flag_mismatch("fix_valid", TEXT_W'(oldest_fix.fix_valid), TEXT_W'(fix_valid_o));
        if (latitude_text_o !== oldest_fix.latitude_text)
          flag_mismatch("latitude_text", oldest_fix.latitude_text, latitude_text_o);
        if (longitude_text_o !== oldest_fix.longitude_text)
          flag_mismatch("longitude_text", oldest_fix.longitude_text, longitude_text_o);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (rx_valid_i && !rx_stall_o) || (res_valid_o && !res_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    phase_model  = HUNT_DOLLAR;
    offset_model = '0;
    status_model = '0;
    lat_capture  = '0;
    lon_capture  = '0;
    lat_shown    = LAT_RESET;
    lon_shown    = LON_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows and the first random phase: sender idles 23%, receiver 48%.
    send_idle_pct  = 23;
    recv_stall_pct = 48;
    foreach (DIRECTED_ROWS[r]) send_sentence(DIRECTED_ROWS[r], 1'b0);
    random_phase(23, 48);
    hold_until_drained();
    // Swap the pressure, then run with no idling at all.
    random_phase(48, 23);
    hold_until_drained();
    random_phase(0, 0);
    hold_until_drained();

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
